// ===== src/swbp_pkg.sv =====
`default_nettype none

package swbp_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_STEP   = 2'd2,
    ACT_TRAP   = 2'd3
  } action_e;

  // Only software breakpoints are handled.
  localparam logic [2:0]  BP_TYPE_SW      = 3'd0;
  localparam logic [7:0]  TRAP_OPCODE_HI  = 8'hC3;
  localparam logic [7:0]  TRAP_NUMBER_RST = 8'h20;
  localparam logic [31:0] PC_REWIND       = 32'h0000_0002;

  typedef struct packed {
    logic load;     // latch the input beat and restart the table walk
    logic scan_en;  // read one table entry
    logic fin;      // decide, update the table and load the first result
    logic load2;    // load the step slot restore as the second result
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic two;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== src/swbp_ctrl.sv =====
`default_nettype none

module swbp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire swbp_pkg::ctrl_sts_t sts_i,
  output swbp_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_OUT1  = 3'd4;
  localparam logic [2:0] S_OUT2  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      // The compare of the last entry read lands here.
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_OUT1;
      end
      S_OUT1: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.two) begin
            cmd_o.load2 = 1'b1;
            state_d     = S_OUT2;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_OUT2: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/swbp_dpath.sv =====
`default_nettype none

module swbp_dpath #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire swbp_pkg::ctrl_cmd_t cmd_i,
  output swbp_pkg::ctrl_sts_t      sts_o,
  input  wire logic [15:0]         trap_word_i,
  input  wire logic [1:0]          action_i,
  input  wire logic [2:0]          bp_type_i,
  input  wire logic [31:0]         addr_i,
  input  wire logic [15:0]         mem_word_i,
  output logic                     status_o,
  output logic                     write_enable_o,
  output logic [31:0]              mem_addr_o,
  output logic [15:0]              mem_data_o,
  output logic [31:0]              resume_pc_o,
  output logic                     last_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  // Latched input beat. key_q is the address looked up in the table.
  swbp_pkg::action_e act_q;
  logic [2:0]        type_q;
  logic [31:0]       addr_q;
  logic [31:0]       key_q;
  logic [15:0]       word_q;

  // Breakpoint table.
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [31:0]            tbl_addr_q [TABLE_DEPTH];
  logic [15:0]            tbl_word_q [TABLE_DEPTH];

  // Table walk.
  logic [IdxW-1:0] cnt_q;
  logic            cmp_go_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic [31:0]     rd_addr_q;
  logic [15:0]     rd_word_q;
  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  logic [15:0]     hit_word_q;
  logic            free_q;
  logic [IdxW-1:0] free_idx_q;
  logic            any_q;

  // Single-step slot.
  logic        stepping_q;
  logic [31:0] step_addr_q;
  logic [15:0] step_word_q;

  logic two_q;

  // Decision.
  logic        addr_zero, type_bad, armed;
  logic        res_st, res_we, res_last;
  logic [31:0] res_maddr, res_pc;
  logic [15:0] res_mdata;
  logic        ins_ok, rem_ok, step_set, step_clr, two;

  assign sts_o.scan_last = (cnt_q == LastIdx);
  assign sts_o.two       = two_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= swbp_pkg::action_e'(action_i);
      type_q <= bp_type_i;
      addr_q <= addr_i;
      word_q <= mem_word_i;
      if (swbp_pkg::action_e'(action_i) == swbp_pkg::ACT_TRAP) begin
        key_q <= addr_i - swbp_pkg::PC_REWIND;
      end else begin
        key_q <= addr_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin && ins_ok) begin
      tbl_addr_q[free_idx_q] <= addr_q;
      tbl_word_q[free_idx_q] <= word_q;
    end
    if (cmd_i.scan_en) begin
      rd_addr_q <= tbl_addr_q[cnt_q];
      rd_word_q <= tbl_word_q[cnt_q];
    end
  end

  // The read of entry n is compared in the next cycle; the first match wins.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      cmp_go_q   <= 1'b0;
      cmp_idx_q  <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      hit_word_q <= '0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      any_q      <= 1'b0;
    end else if (cmd_i.load) begin
      cnt_q    <= '0;
      cmp_go_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      any_q    <= 1'b0;
    end else begin
      cmp_go_q  <= cmd_i.scan_en;
      cmp_idx_q <= cnt_q;
      if (cmd_i.scan_en) begin
        cnt_q <= cnt_q + 1'b1;
        any_q <= any_q | valid_q[cnt_q];
        if (!free_q && !valid_q[cnt_q]) begin
          free_q     <= 1'b1;
          free_idx_q <= cnt_q;
        end
      end
      if (cmp_go_q && !hit_q && valid_q[cmp_idx_q] && (rd_addr_q == key_q)) begin
        hit_q      <= 1'b1;
        hit_idx_q  <= cmp_idx_q;
        hit_word_q <= rd_word_q;
      end
    end
  end

  always_comb begin
    addr_zero = (addr_q == 32'd0);
    type_bad  = (type_q != swbp_pkg::BP_TYPE_SW);
    armed     = stepping_q | any_q;
    res_st    = 1'b0;
    res_we    = 1'b0;
    res_maddr = '0;
    res_mdata = '0;
    res_pc    = addr_q;
    res_last  = 1'b1;
    ins_ok    = 1'b0;
    rem_ok    = 1'b0;
    step_set  = 1'b0;
    step_clr  = 1'b0;
    two       = 1'b0;
    unique case (act_q)
      swbp_pkg::ACT_INSERT: begin
        if (addr_zero || type_bad) begin
          res_st = 1'b1;
        end else if (hit_q) begin
          res_st = 1'b0;
        end else if (!free_q) begin
          res_st = 1'b1;
        end else begin
          ins_ok    = 1'b1;
          res_we    = 1'b1;
          res_maddr = addr_q;
          res_mdata = trap_word_i;
        end
      end
      swbp_pkg::ACT_REMOVE: begin
        if (addr_zero || type_bad || !hit_q) begin
          res_st = 1'b1;
        end else begin
          rem_ok    = 1'b1;
          res_we    = 1'b1;
          res_maddr = addr_q;
          res_mdata = hit_word_q;
        end
      end
      swbp_pkg::ACT_STEP: begin
        if (addr_zero) begin
          res_st = 1'b1;
        end else begin
          step_set  = 1'b1;
          res_we    = 1'b1;
          res_maddr = addr_q;
          res_mdata = trap_word_i;
        end
      end
      swbp_pkg::ACT_TRAP: begin
        if (armed) begin
          res_pc = key_q;
          if (hit_q) begin
            res_we    = 1'b1;
            res_maddr = key_q;
            res_mdata = hit_word_q;
            res_last  = !stepping_q;
            two       = stepping_q;
          end else if (stepping_q) begin
            res_we    = 1'b1;
            res_maddr = step_addr_q;
            res_mdata = step_word_q;
            step_clr  = 1'b1;
          end
        end
      end
      default: begin
        res_st = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      stepping_q  <= 1'b0;
      step_addr_q <= '0;
      step_word_q <= '0;
      two_q       <= 1'b0;
    end else begin
      if (cmd_i.fin) begin
        two_q <= two;
        if (ins_ok) begin
          valid_q[free_idx_q] <= 1'b1;
        end
        if (rem_ok) begin
          valid_q[hit_idx_q] <= 1'b0;
        end
        if (step_set) begin
          stepping_q  <= 1'b1;
          step_addr_q <= addr_q;
          step_word_q <= word_q;
        end
      end
      if ((cmd_i.fin && step_clr) || cmd_i.load2) begin
        stepping_q  <= 1'b0;
        step_addr_q <= '0;
        step_word_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      status_o       <= res_st;
      write_enable_o <= res_we;
      mem_addr_o     <= res_maddr;
      mem_data_o     <= res_mdata;
      resume_pc_o    <= res_pc;
      last_o         <= res_last;
    end else if (cmd_i.load2) begin
      status_o       <= 1'b0;
      write_enable_o <= 1'b1;
      mem_addr_o     <= step_addr_q;
      mem_data_o     <= step_word_q;
      last_o         <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== src/software_breakpoint_table_top.sv =====
// Software breakpoint table with one single-step slot.
// Input channel (in_valid_i/in_ready_o) takes one action per beat: insert,
// remove, arm step or trap entry, with the type, address and current memory
// word. Output channel (out_valid_o/out_ready_i) returns one or two result
// beats per action: status, a program-memory write and the resume PC; last_o
// marks the final beat of an action.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes the trap number; it
// is always ready and should only be written while the block is idle.
// Each action walks the whole table, one entry read per cycle from the
// address and word memories; after a drain state the decision state loads
// the first result into the output register. One action is in flight at a
// time: the next input beat is taken in the cycle after the last result beat
// leaves. A stalled receiver holds the result in the output register and the
// block waits. Reset empties the table, disarms the step slot and sets the
// trap number to 32.
`default_nettype none

module software_breakpoint_table_top #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [2:0]  bp_type_i,
  input  wire logic [31:0] addr_i,
  input  wire logic [15:0] mem_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             status_o,
  output logic             write_enable_o,
  output logic [31:0]      mem_addr_o,
  output logic [15:0]      mem_data_o,
  output logic [31:0]      resume_pc_o,
  output logic             last_o
);

  logic [7:0]          trap_num_q;
  swbp_pkg::ctrl_cmd_t cmd;
  swbp_pkg::ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trap_num_q <= swbp_pkg::TRAP_NUMBER_RST;
    end else if (cfg_valid_i) begin
      trap_num_q <= cfg_data_i;
    end
  end

  swbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swbp_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .trap_word_i    ({swbp_pkg::TRAP_OPCODE_HI, trap_num_q}),
    .action_i       (action_i),
    .bp_type_i      (bp_type_i),
    .addr_i         (addr_i),
    .mem_word_i     (mem_word_i),
    .status_o       (status_o),
    .write_enable_o (write_enable_o),
    .mem_addr_o     (mem_addr_o),
    .mem_data_o     (mem_data_o),
    .resume_pc_o    (resume_pc_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb_software_breakpoint_table_top.sv =====
`default_nettype none

module tb_software_breakpoint_table_top;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int unsigned PHASE_ITEMS = 340;

  typedef struct packed {
    logic        status;
    logic        write_enable;
    logic [31:0] mem_addr;
    logic [15:0] mem_data;
    logic [31:0] resume_pc;
    logic        last;
  } patch_beat_t;

  typedef struct packed {
    swbp_pkg::action_e act;
    logic [2:0]        bp_type;
    logic [31:0]       addr;
    logic [15:0]       mem_word;
    logic              typed;
    patch_beat_t       want;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [2:0]  bp_type_i;
  logic [31:0] addr_i;
  logic [15:0] mem_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        status_o;
  logic        write_enable_o;
  logic [31:0] mem_addr_o;
  logic [15:0] mem_data_o;
  logic [31:0] resume_pc_o;
  logic        last_o;

  // Shadow copy of the breakpoint table, step slot and trap number.
  bit          bp_valid [TABLE_DEPTH];
  logic [31:0] bp_addr  [TABLE_DEPTH];
  logic [15:0] bp_word  [TABLE_DEPTH];
  bit          step_armed;
  logic [31:0] step_pc;
  logic [15:0] step_word;
  logic [7:0]  trap_num;

  patch_beat_t new_beats[$];
  patch_beat_t awaited_patches[$];
  logic [31:0] addr_pool[POOL_SIZE];
  script_row_t script[20];
  int          mismatch_count = 0;
  bit          idling_enabled = 1'b1;
  int          stall_left = 0;

  software_breakpoint_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .bp_type_i     (bp_type_i),
    .addr_i        (addr_i),
    .mem_word_i    (mem_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .write_enable_o(write_enable_o),
    .mem_addr_o    (mem_addr_o),
    .mem_data_o    (mem_data_o),
    .resume_pc_o   (resume_pc_o),
    .last_o        (last_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic patch_beat_t make_beat(logic st, logic we, logic [31:0] ma,
                                            logic [15:0] md, logic [31:0] pc, logic lst);
    patch_beat_t b;
    b.status       = st;
    b.write_enable = we;
    b.mem_addr     = we ? ma : 32'h0;
    b.mem_data     = we ? md : 16'h0;
    b.resume_pc    = pc;
    b.last         = lst;
    return b;
  endfunction

  function automatic script_row_t make_row(swbp_pkg::action_e act, logic [2:0] ty,
                                           logic [31:0] a, logic [15:0] w, logic typed,
                                           patch_beat_t want);
    script_row_t r;
    r.act      = act;
    r.bp_type  = ty;
    r.addr     = a;
    r.mem_word = w;
    r.typed    = typed;
    r.want     = want;
    return r;
  endfunction

  // Works out the memory patch beats for one action and updates the shadow table.
  task automatic compute_patch_beats(input swbp_pkg::action_e act, input logic [2:0] ty,
                                     input logic [31:0] a, input logic [15:0] w);
    logic [15:0] trap_word;
    logic [31:0] pc;
    logic [31:0] key;
    int          hit;
    int          free_slot;
    bit          any_bp;
    trap_word = {swbp_pkg::TRAP_OPCODE_HI, trap_num};
    pc = a - swbp_pkg::PC_REWIND;
    key = (act == swbp_pkg::ACT_TRAP) ? pc : a;
    hit = -1;
    free_slot = -1;
    any_bp = 1'b0;
    new_beats.delete();
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (bp_valid[k]) begin
        any_bp = 1'b1;
        if (bp_addr[k] == key && hit < 0) hit = k;
      end else if (free_slot < 0) begin
        free_slot = k;
      end
    end
    case (act)
      swbp_pkg::ACT_INSERT: begin
        if (a == '0 || ty != swbp_pkg::BP_TYPE_SW || (hit < 0 && free_slot < 0)) begin
          new_beats.push_back(make_beat(1'b1, 1'b0, '0, '0, a, 1'b1));
        end else if (hit >= 0) begin
          new_beats.push_back(make_beat(1'b0, 1'b0, '0, '0, a, 1'b1));
        end else begin
          bp_valid[free_slot] = 1'b1;
          bp_addr[free_slot]  = a;
          bp_word[free_slot]  = w;
          new_beats.push_back(make_beat(1'b0, 1'b1, a, trap_word, a, 1'b1));
        end
      end
      swbp_pkg::ACT_REMOVE: begin
        if (a == '0 || ty != swbp_pkg::BP_TYPE_SW || hit < 0) begin
          new_beats.push_back(make_beat(1'b1, 1'b0, '0, '0, a, 1'b1));
        end else begin
          bp_valid[hit] = 1'b0;
          new_beats.push_back(make_beat(1'b0, 1'b1, a, bp_word[hit], a, 1'b1));
        end
      end
      swbp_pkg::ACT_STEP: begin
        if (a == '0) begin
          new_beats.push_back(make_beat(1'b1, 1'b0, '0, '0, a, 1'b1));
        end else begin
          step_armed = 1'b1;
          step_pc    = a;
          step_word  = w;
          new_beats.push_back(make_beat(1'b0, 1'b1, a, trap_word, a, 1'b1));
        end
      end
      default: begin
        if (!step_armed && !any_bp) begin
          new_beats.push_back(make_beat(1'b0, 1'b0, '0, '0, a, 1'b1));
        end else begin
          // A breakpoint hit is restored but stays in the table.
          if (hit >= 0)
            new_beats.push_back(make_beat(1'b0, 1'b1, pc, bp_word[hit], pc, !step_armed));
          if (step_armed) begin
            new_beats.push_back(make_beat(1'b0, 1'b1, step_pc, step_word, pc, 1'b1));
            step_armed = 1'b0;
            step_pc    = '0;
            step_word  = '0;
          end
          if (new_beats.size() == 0)
            new_beats.push_back(make_beat(1'b0, 1'b0, '0, '0, pc, 1'b1));
        end
      end
    endcase
  endtask

  task automatic send_action(input swbp_pkg::action_e act, input logic [2:0] ty,
                             input logic [31:0] a, input logic [15:0] w,
                             input logic typed, input patch_beat_t want);
    int gap;
    @(negedge clk_i);
    if (idling_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    bp_type_i  <= ty;
    addr_i     <= a;
    mem_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    compute_patch_beats(act, ty, a, w);
    if (typed) begin
      awaited_patches.push_back(want);
    end else begin
      foreach (new_beats[k]) awaited_patches.push_back(new_beats[k]);
    end
  endtask

  // Stops the sender and lets every outstanding beat come back.
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_patches.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
  endtask

  task automatic write_trap_number(input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    trap_num = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random_phase();
    logic [31:0]       tmp;
    logic [31:0]       a;
    logic [2:0]        ty;
    swbp_pkg::action_e act;
    int                sel;
    // Distinct addresses per phase: the index sits in bits 5:1.
    for (int k = 0; k < POOL_SIZE; k++) begin
      tmp = $urandom();
      addr_pool[k] = {tmp[31:6], k[4:0], tmp[0]};
      if (addr_pool[k] == '0) addr_pool[k] = 32'h1;
    end
    // Seventeen fresh addresses always overflow a sixteen-entry table.
    for (int k = 0; k <= TABLE_DEPTH; k++)
      send_action(swbp_pkg::ACT_INSERT, swbp_pkg::BP_TYPE_SW, addr_pool[k],
                  16'($urandom()), 1'b0, '0);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      a   = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      ty  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 4)) : swbp_pkg::BP_TYPE_SW;
      if (sel < 35) begin
        act = swbp_pkg::ACT_INSERT;
      end else if (sel < 55) begin
        act = swbp_pkg::ACT_REMOVE;
      end else if (sel < 65) begin
        act = swbp_pkg::ACT_STEP;
      end else if (sel < 88) begin
        act = swbp_pkg::ACT_TRAP;
        a = ($urandom_range(0, 4) == 0) ? 32'($urandom()) : a + swbp_pkg::PC_REWIND;
      end else begin
        act = swbp_pkg::action_e'($urandom_range(0, 3));
        a   = $urandom();
        ty  = 3'($urandom_range(0, 4));
      end
      if ($urandom_range(0, 49) == 0) a = '0;
      send_action(act, ty, a, 16'($urandom()), 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idling_enabled && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    patch_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_patches.size() == 0) begin
        $error("result beat with nothing expected: mem_addr %0h resume_pc %0h",
               mem_addr_o, resume_pc_o);
        mismatch_count++;
      end else begin
        want = awaited_patches.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("write_enable", 32'(want.write_enable), 32'(write_enable_o));
        check_field("mem_addr", want.mem_addr, mem_addr_o);
        check_field("mem_data", 32'(want.mem_data), 32'(mem_data_o));
        check_field("resume_pc", want.resume_pc, resume_pc_o);
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  initial begin
    #(8 * 1_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [15:0] tw;
    logic [7:0]  cfg_values[4];
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    action_i    = swbp_pkg::ACT_INSERT;
    bp_type_i   = swbp_pkg::BP_TYPE_SW;
    addr_i      = '0;
    mem_word_i  = '0;
    out_ready_i = 1'b0;
    for (int k = 0; k < TABLE_DEPTH; k++) bp_valid[k] = 1'b0;
    step_armed = 1'b0;
    step_pc    = '0;
    step_word  = '0;
    trap_num   = swbp_pkg::TRAP_NUMBER_RST;
    tw = {swbp_pkg::TRAP_OPCODE_HI, swbp_pkg::TRAP_NUMBER_RST};

    script[0]  = make_row(swbp_pkg::ACT_TRAP, 3'd0, 32'h1000, 16'hBEEF, 1'b1,
                          make_beat(1'b0, 1'b0, '0, '0, 32'h1000, 1'b1));
    script[1]  = make_row(swbp_pkg::ACT_INSERT, 3'd0, 32'h0, 16'h1111, 1'b1,
                          make_beat(1'b1, 1'b0, '0, '0, 32'h0, 1'b1));
    script[2]  = make_row(swbp_pkg::ACT_INSERT, 3'd4, 32'h100, 16'h2222, 1'b1,
                          make_beat(1'b1, 1'b0, '0, '0, 32'h100, 1'b1));
    script[3]  = make_row(swbp_pkg::ACT_INSERT, 3'd0, 32'h100, 16'hFFFF, 1'b1,
                          make_beat(1'b0, 1'b1, 32'h100, tw, 32'h100, 1'b1));
    script[4]  = make_row(swbp_pkg::ACT_INSERT, 3'd0, 32'h100, 16'h0000, 1'b1,
                          make_beat(1'b0, 1'b0, '0, '0, 32'h100, 1'b1));
    script[5]  = make_row(swbp_pkg::ACT_INSERT, 3'd0, 32'hFFFF_FFFF, 16'h0000, 1'b1,
                          make_beat(1'b0, 1'b1, 32'hFFFF_FFFF, tw, 32'hFFFF_FFFF, 1'b1));
    script[6]  = make_row(swbp_pkg::ACT_REMOVE, 3'd0, 32'h200, 16'h3333, 1'b1,
                          make_beat(1'b1, 1'b0, '0, '0, 32'h200, 1'b1));
    script[7]  = make_row(swbp_pkg::ACT_REMOVE, 3'd1, 32'h100, 16'h0, 1'b1,
                          make_beat(1'b1, 1'b0, '0, '0, 32'h100, 1'b1));
    script[8]  = make_row(swbp_pkg::ACT_REMOVE, 3'd0, 32'h0, 16'h0, 1'b1,
                          make_beat(1'b1, 1'b0, '0, '0, 32'h0, 1'b1));
    script[9]  = make_row(swbp_pkg::ACT_STEP, 3'd0, 32'h0, 16'h4444, 1'b1,
                          make_beat(1'b1, 1'b0, '0, '0, 32'h0, 1'b1));
    script[10] = make_row(swbp_pkg::ACT_STEP, 3'd0, 32'h400, 16'h1234, 1'b1,
                          make_beat(1'b0, 1'b1, 32'h400, tw, 32'h400, 1'b1));
    script[11] = make_row(swbp_pkg::ACT_STEP, 3'd0, 32'h500, 16'h5678, 1'b1,
                          make_beat(1'b0, 1'b1, 32'h500, tw, 32'h500, 1'b1));
    // Breakpoint hit with the step slot armed gives two beats.
    script[12] = make_row(swbp_pkg::ACT_TRAP, 3'd0, 32'h102, 16'h0, 1'b0, '0);
    script[13] = make_row(swbp_pkg::ACT_TRAP, 3'd4, 32'h102, 16'hAAAA, 1'b0, '0);
    script[14] = make_row(swbp_pkg::ACT_TRAP, 3'd0, 32'h3000, 16'h0, 1'b1,
                          make_beat(1'b0, 1'b0, '0, '0, 32'h2FFE, 1'b1));
    script[15] = make_row(swbp_pkg::ACT_REMOVE, 3'd0, 32'h100, 16'hCCCC, 1'b0, '0);
    script[16] = make_row(swbp_pkg::ACT_REMOVE, 3'd0, 32'hFFFF_FFFF, 16'h0, 1'b0, '0);
    script[17] = make_row(swbp_pkg::ACT_STEP, 3'd4, 32'h1, 16'hA5A5, 1'b0, '0);
    // The stacked PC wraps below zero here.
    script[18] = make_row(swbp_pkg::ACT_TRAP, 3'd0, 32'h0, 16'h0, 1'b0, '0);
    script[19] = make_row(swbp_pkg::ACT_TRAP, 3'd0, 32'h0, 16'h0, 1'b1,
                          make_beat(1'b0, 1'b0, '0, '0, 32'h0, 1'b1));

    cfg_values[0] = 8'h00;
    cfg_values[1] = 8'hFF;
    cfg_values[2] = 8'($urandom_range(1, 254));
    cfg_values[3] = 8'($urandom_range(1, 254));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[k])
      send_action(script[k].act, script[k].bp_type, script[k].addr, script[k].mem_word,
                  script[k].typed, script[k].want);

    for (int p = 0; p < 4; p++) begin
      drain_block();
      write_trap_number(cfg_values[p]);
      idling_enabled = (p != 3);
      run_random_phase();
    end
    drain_block();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
